/* rtl/team_grouped_queue_macros.svh */
// Assertion macros shared by the team queue RTL.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef TEAM_GROUPED_QUEUE_MACROS_SVH
`define TEAM_GROUPED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TGQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TGQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tgq_pkg.sv */
// Types and constants of the team queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tgq_pkg;

    // Fixed field widths
    localparam int TEAM_W = 10;
    localparam int OCC_W  = 11;

    // Command codes
    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } command_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

/* rtl/team_grouped_queue.sv */
// Team queue: FIFO where an element joins right behind the last queued member
// of its own team, or at the tail when its team has nothing queued.
// Input channel (in_valid / in_stall): command, element, team. A transaction
// is taken when in_valid is high and in_stall low; in_stall is high while an
// operation is in flight. Output channel (out_valid / out_stall): one result
// per input transaction with status, out_element, out_team, occupancy.
// The next input is taken only once the result of the last one has loaded into
// the result register. A full enqueue or an empty dequeue goes straight to the
// reply; any other operation goes through the node memory, which has one read
// and one write port: read the recycled or head node, map the team and read its
// slot, read the team's last member if the element joins behind it, then one or
// two node writes for the relinking.
// A finished result waits in the output register while out_stall is high; the
// block then holds its last operation until the register frees up.
// After reset the team table is swept clear with in_stall high.
`timescale 1ns / 1ps

module team_grouped_queue
    import tgq_pkg::*;
#(
    parameter int CAPACITY      = 1024,
    parameter int TEAMS         = 1024,
    parameter int ELEMENT_WIDTH = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [ELEMENT_WIDTH-1:0] element,
    input  logic [TEAM_W-1:0]        team,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [ELEMENT_WIDTH-1:0] out_element,
    output logic [TEAM_W-1:0]        out_team,
    output logic [OCC_W-1:0]         occupancy
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int TIW = (TEAMS > 1) ? $clog2(TEAMS) : 1;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_FETCH  = 8'b0000_0100,
        S_INDEX  = 8'b0000_1000,
        S_LINK   = 8'b0001_0000,
        S_SPLICE = 8'b0010_0000,
        S_PATCH  = 8'b0100_0000,
        S_REPLY  = 8'b1000_0000
    } state_t;

    // Control registers
    state_t         state_reg, state_next;
    logic [TIW-1:0] clr_reg, clr_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  tail_reg, tail_next;
    logic [AW-1:0]  free_head_reg, free_head_next;
    logic [CW-1:0]  queued_reg, queued_next;
    logic [CW-1:0]  fresh_reg, fresh_next;
    logic           out_valid_reg, out_valid_next;

    // Operation registers
    command_t                 cmd_reg, cmd_next;
    logic [ELEMENT_WIDTH-1:0] elem_reg, elem_next;
    logic [TEAM_W-1:0]        team_reg, team_next;
    logic [AW-1:0]            link_reg, link_next;
    logic [TIW-1:0]           ti_reg, ti_next;
    logic [AW-1:0]            n_reg, n_next;
    logic [AW-1:0]            prev_reg, prev_next;
    status_t                  pend_reg, pend_next;

    // Result registers
    status_t                  status_reg, status_next;
    logic [ELEMENT_WIDTH-1:0] out_elem_reg, out_elem_next;
    logic [TEAM_W-1:0]        out_team_reg, out_team_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;

    // Memory ports
    logic                     node_rd_en;
    logic [AW-1:0]            node_rd_addr;
    logic [ELEMENT_WIDTH-1:0] node_rd_element;
    logic [TEAM_W-1:0]        node_rd_team;
    logic [AW-1:0]            node_rd_next;
    logic [AW-1:0]            node_wr_addr;
    logic                     node_wr_data_en;
    logic                     node_wr_next_en;
    logic [AW-1:0]            node_wr_next;

    logic                     tt_rd_en;
    logic                     tt_rd_valid;
    logic [AW-1:0]            tt_rd_node;
    logic                     tt_wr_en;
    logic [TIW-1:0]           tt_wr_addr;
    logic                     tt_wr_valid;
    logic [AW-1:0]            tt_wr_node;

    logic                     idx_load;
    logic [TEAM_W-1:0]        idx_team;
    logic [TIW-1:0]           idx_slot;

    // Derived conditions
    logic          free_avail;
    logic          q_full;
    logic          q_empty;
    logic [AW-1:0] n_take;
    logic          out_load;

    assign free_avail = (fresh_reg != queued_reg);
    assign q_full     = (queued_reg == CW'(CAPACITY));
    assign q_empty    = (queued_reg == '0);
    assign n_take     = free_avail ? free_head_reg : AW'(fresh_reg);
    assign out_load   = (state_reg == S_REPLY) && (!out_valid_reg || !out_stall);

    tgq_node_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .EW       (ELEMENT_WIDTH)
    ) u_node_mem (
        .clk        (clk),
        .rd_en      (node_rd_en),
        .rd_addr    (node_rd_addr),
        .rd_element (node_rd_element),
        .rd_team    (node_rd_team),
        .rd_next    (node_rd_next),
        .wr_addr    (node_wr_addr),
        .wr_data_en (node_wr_data_en),
        .wr_element (elem_reg),
        .wr_team    (team_reg),
        .wr_next_en (node_wr_next_en),
        .wr_next    (node_wr_next)
    );

    tgq_tail_mem #(
        .TEAMS (TEAMS),
        .TIW   (TIW),
        .AW    (AW)
    ) u_tail_mem (
        .clk      (clk),
        .rd_en    (tt_rd_en),
        .rd_addr  (idx_slot),
        .rd_valid (tt_rd_valid),
        .rd_node  (tt_rd_node),
        .wr_en    (tt_wr_en),
        .wr_addr  (tt_wr_addr),
        .wr_valid (tt_wr_valid),
        .wr_node  (tt_wr_node)
    );

    tgq_team_index #(
        .TEAMS (TEAMS),
        .TIW   (TIW)
    ) u_team_index (
        .clk     (clk),
        .load    (idx_load),
        .team_in (idx_team),
        .slot    (idx_slot)
    );

    // Sequence one operation: fetch node, map team, relink, reply
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_head_next  = free_head_reg;
        queued_next     = queued_reg;
        fresh_next      = fresh_reg;
        cmd_next        = cmd_reg;
        elem_next       = elem_reg;
        team_next       = team_reg;
        link_next       = link_reg;
        ti_next         = ti_reg;
        n_next          = n_reg;
        prev_next       = prev_reg;
        pend_next       = pend_reg;

        node_rd_en      = 1'b0;
        node_rd_addr    = head_reg;
        node_wr_addr    = n_reg;
        node_wr_data_en = 1'b0;
        node_wr_next_en = 1'b0;
        node_wr_next    = n_reg;
        tt_rd_en        = 1'b0;
        tt_wr_en        = 1'b0;
        tt_wr_addr      = ti_reg;
        tt_wr_valid     = 1'b0;
        tt_wr_node      = n_reg;
        idx_load        = 1'b0;
        idx_team        = team_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the team table invalid
                tt_wr_en   = 1'b1;
                tt_wr_addr = clr_reg;
                if (clr_reg == TIW'(TEAMS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = command_t'(command);
                    elem_next = element;
                    team_next = team;
                    if (command_t'(command) == CMD_DEQ)
                    begin
                        if (q_empty)
                        begin
                            pend_next  = ST_EMPTY;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            node_rd_en   = 1'b1;
                            node_rd_addr = head_reg;
                            state_next   = S_FETCH;
                        end
                    end
                    else
                    begin
                        if (q_full)
                        begin
                            pend_next  = ST_FULL;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            // Successor on the free list, used only if it is not empty
                            node_rd_en   = 1'b1;
                            node_rd_addr = free_head_reg;
                            state_next   = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                link_next = node_rd_next;
                idx_load  = 1'b1;
                if (cmd_reg == CMD_DEQ)
                begin
                    elem_next = node_rd_element;
                    team_next = node_rd_team;
                    idx_team  = node_rd_team;
                end
                state_next = S_INDEX;
            end

            S_INDEX:
            begin
                tt_rd_en   = 1'b1;
                ti_next    = idx_slot;
                state_next = S_LINK;
            end

            S_LINK:
            begin
                if (cmd_reg == CMD_DEQ)
                begin
                    // Drop the team mark if the head was its last member
                    if (tt_rd_valid && (tt_rd_node == head_reg))
                    begin
                        tt_wr_en    = 1'b1;
                        tt_wr_valid = 1'b0;
                    end
                    // Advance head, push the node onto the free list
                    head_next       = link_reg;
                    node_wr_addr    = head_reg;
                    node_wr_next_en = 1'b1;
                    node_wr_next    = free_head_reg;
                    free_head_next  = head_reg;
                    queued_next     = queued_reg - 1'b1;
                    pend_next       = ST_DEQ;
                    state_next      = S_REPLY;
                end
                else
                begin
                    n_next = n_take;
                    if (free_avail)
                    begin
                        free_head_next = link_reg;
                    end
                    else
                    begin
                        fresh_next = fresh_reg + 1'b1;
                    end
                    tt_wr_en    = 1'b1;
                    tt_wr_valid = 1'b1;
                    tt_wr_node  = n_take;
                    queued_next = queued_reg + 1'b1;
                    pend_next   = ST_ENQ;
                    if (q_empty)
                    begin
                        head_next       = n_take;
                        tail_next       = n_take;
                        node_wr_addr    = n_take;
                        node_wr_data_en = 1'b1;
                        state_next      = S_REPLY;
                    end
                    else if (!tt_rd_valid)
                    begin
                        // Append at the tail
                        node_wr_addr    = n_take;
                        node_wr_data_en = 1'b1;
                        prev_next       = tail_reg;
                        tail_next       = n_take;
                        state_next      = S_PATCH;
                    end
                    else
                    begin
                        // Insert behind the team's last member
                        node_rd_en   = 1'b1;
                        node_rd_addr = tt_rd_node;
                        prev_next    = tt_rd_node;
                        if (tt_rd_node == tail_reg)
                        begin
                            tail_next = n_take;
                        end
                        state_next = S_SPLICE;
                    end
                end
            end

            S_SPLICE:
            begin
                // New node inherits the successor of the team's last member
                node_wr_addr    = n_reg;
                node_wr_data_en = 1'b1;
                node_wr_next_en = 1'b1;
                node_wr_next    = node_rd_next;
                state_next      = S_PATCH;
            end

            S_PATCH:
            begin
                node_wr_addr    = prev_reg;
                node_wr_next_en = 1'b1;
                node_wr_next    = n_reg;
                state_next      = S_REPLY;
            end

            S_REPLY:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register: load on reply, drop once taken
    always_comb
    begin
        status_next    = status_reg;
        out_elem_next  = out_elem_reg;
        out_team_next  = out_team_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = pend_reg;
            out_elem_next  = (pend_reg == ST_DEQ) ? elem_reg : '0;
            out_team_next  = (pend_reg == ST_DEQ) ? team_reg : '0;
            occ_next       = OCC_W'(queued_reg);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_head_reg <= '0;
            queued_reg    <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            queued_reg    <= queued_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        elem_reg     <= elem_next;
        team_reg     <= team_next;
        link_reg     <= link_next;
        ti_reg       <= ti_next;
        n_reg        <= n_next;
        prev_reg     <= prev_next;
        pend_reg     <= pend_next;
        status_reg   <= status_next;
        out_elem_reg <= out_elem_next;
        out_team_reg <= out_team_next;
        occ_reg      <= occ_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_element = out_elem_reg;
    assign out_team    = out_team_reg;
    assign occupancy   = occ_reg;

`include "team_grouped_queue_macros.svh"

    `TGQ_ASSERT_NOW(a_queued_bound, 1'b1, queued_reg <= CW'(CAPACITY),
                    "queued count beyond capacity")
    `TGQ_ASSERT_NOW(a_fresh_covers_queued, 1'b1, fresh_reg >= queued_reg,
                    "more nodes queued than handed out")
    `TGQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                     "input taken while an operation is in flight")
    `TGQ_ASSERT_NOW(a_zero_fields, out_valid && (status != ST_DEQ),
                    (out_element == '0) && (out_team == '0),
                    "element or team set on a non-dequeue result")

endmodule

/* rtl/tgq_node_mem.sv */
// Node memory of the team queue: element, team and next link per node.
// Depends on tgq_pkg. One read port with registered data, one write port
// with separate enables for the payload part and the link part.
`timescale 1ns / 1ps

module tgq_node_mem
    import tgq_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int AW       = 10,
    parameter int EW       = 20
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [EW-1:0]     rd_element,
    output logic [TEAM_W-1:0] rd_team,
    output logic [AW-1:0]     rd_next,
    input  logic [AW-1:0]     wr_addr,
    input  logic              wr_data_en,
    input  logic [EW-1:0]     wr_element,
    input  logic [TEAM_W-1:0] wr_team,
    input  logic              wr_next_en,
    input  logic [AW-1:0]     wr_next
);

    localparam int DW = EW + TEAM_W + AW;

    logic [DW-1:0] mem [CAPACITY];
    logic [DW-1:0] rd_data_reg;

    // Write payload and link fields independently
    always_ff @(posedge clk)
    begin
        if (wr_data_en)
        begin
            mem[wr_addr][DW-1:AW] <= {wr_element, wr_team};
        end
        if (wr_next_en)
        begin
            mem[wr_addr][AW-1:0] <= wr_next;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_element = rd_data_reg[DW-1:TEAM_W+AW];
    assign rd_team    = rd_data_reg[TEAM_W+AW-1:AW];
    assign rd_next    = rd_data_reg[AW-1:0];

endmodule

/* rtl/tgq_tail_mem.sv */
// Per-team last-member table: valid flag plus node index for each team slot.
// Depends on tgq_pkg. One read port with registered data, one write port.
`timescale 1ns / 1ps

module tgq_tail_mem
    import tgq_pkg::*;
#(
    parameter int TEAMS = 1024,
    parameter int TIW   = 10,
    parameter int AW    = 10
)
(
    input  logic           clk,
    input  logic           rd_en,
    input  logic [TIW-1:0] rd_addr,
    output logic           rd_valid,
    output logic [AW-1:0]  rd_node,
    input  logic           wr_en,
    input  logic [TIW-1:0] wr_addr,
    input  logic           wr_valid,
    input  logic [AW-1:0]  wr_node
);

    logic [AW:0] mem [TEAMS];
    logic [AW:0] rd_data_reg;

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_valid, wr_node};
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_valid = rd_data_reg[AW];
    assign rd_node  = rd_data_reg[AW-1:0];

endmodule

/* rtl/tgq_team_index.sv */
// Maps a team number to its slot in the last-member table (team mod TEAMS).
// Depends on tgq_pkg. Quotient by reciprocal multiply in the load cycle,
// remainder from the registered quotient in the following cycle.
`timescale 1ns / 1ps

module tgq_team_index
    import tgq_pkg::*;
#(
    parameter int TEAMS = 1024,
    parameter int TIW   = 10
)
(
    input  logic              clk,
    input  logic              load,
    input  logic [TEAM_W-1:0] team_in,
    output logic [TIW-1:0]    slot
);

    // ceil(2^SHIFT / TEAMS); exact quotient for every team below 2^TEAM_W
    localparam int SHIFT  = 22;
    localparam int RECIP  = ((1 << SHIFT) + TEAMS - 1) / TEAMS;
    localparam int PROD_W = TEAM_W + SHIFT + 2;

    logic [TEAM_W-1:0] team_reg;
    logic [TEAM_W-1:0] quot_reg;
    logic [PROD_W-1:0] prod;
    logic [TEAM_W-1:0] rem;

    assign prod = PROD_W'(team_in) * PROD_W'(RECIP);

    // Capture team and quotient
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            team_reg <= team_in;
            quot_reg <= TEAM_W'(prod >> SHIFT);
        end
    end

    // Remainder from the registered quotient
    assign rem  = team_reg - TEAM_W'(quot_reg * TEAMS);
    assign slot = TIW'(rem);

endmodule

/* tb/sv/team_grouped_queue_test.sv */
// Self-checking testbench for team_grouped_queue: directed, full-queue, random and
// back-pressure tests checked against a behavioral predictor of the team queue.
// Depends on tgq_pkg and the team_grouped_queue RTL.
`timescale 1ns / 1ps

module team_grouped_queue_test;
    import tgq_pkg::*;

    localparam int QUEUE_SLOTS = 1024;
    localparam int TEAM_SLOTS  = 1024;
    localparam int ELEM_W      = 20;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [ELEM_W-1:0] ELEM_MAX = '1;
    localparam logic [TEAM_W-1:0] TEAM_MAX = '1;

    typedef struct {
        status_t             status;
        logic [ELEM_W-1:0]   element;
        logic [TEAM_W-1:0]   team;
        logic [OCC_W-1:0]    occupancy;
    } queue_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                command = CMD_ENQ;
    logic [ELEM_W-1:0]   element = '0;
    logic [TEAM_W-1:0]   team = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          status;
    logic [ELEM_W-1:0]   out_element;
    logic [TEAM_W-1:0]   out_team;
    logic [OCC_W-1:0]    occupancy;

    // Traffic shaping shared by the sender task and the receiver process
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned stall_hold = 0;

    // Predictor state: linked node store, team last-member table, free list
    logic [ELEM_W-1:0]   node_value [QUEUE_SLOTS];
    logic [TEAM_W-1:0]   node_group [QUEUE_SLOTS];
    int unsigned         node_link  [QUEUE_SLOTS];
    bit                  group_open [TEAM_SLOTS];
    int unsigned         group_last [TEAM_SLOTS];
    int unsigned         head_idx;
    int unsigned         tail_idx;
    int unsigned         model_depth;
    int unsigned         pool_used;
    int unsigned         recycle_head;
    bit                  recycle_ok;

    queue_result_t       pending_results [$];
    int                  mismatch_count = 0;

    team_grouped_queue #(
        .CAPACITY      (QUEUE_SLOTS),
        .TEAMS         (TEAM_SLOTS),
        .ELEMENT_WIDTH (ELEM_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .element     (element),
        .team        (team),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_element (out_element),
        .out_team    (out_team),
        .occupancy   (occupancy)
    );

    // Generate the 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Clear the predictor to its reset state
    task automatic clear_model();
        for (int i = 0; i < QUEUE_SLOTS; i++)
        begin
            node_value[i] = '0;
            node_group[i] = '0;
            node_link[i]  = 0;
        end
        for (int i = 0; i < TEAM_SLOTS; i++)
        begin
            group_open[i] = 1'b0;
            group_last[i] = 0;
        end
        head_idx     = 0;
        tail_idx     = 0;
        model_depth  = 0;
        pool_used    = 0;
        recycle_head = 0;
        recycle_ok   = 1'b0;
    endtask

    // Advance the team queue by one command and return its result
    function automatic queue_result_t team_queue_step(input command_t op,
                                                      input logic [ELEM_W-1:0] value,
                                                      input logic [TEAM_W-1:0] grp);
        queue_result_t r;
        int unsigned   slot;
        int unsigned   last;
        int unsigned   grp_idx;
        r.status  = ST_ENQ;
        r.element = '0;
        r.team    = '0;
        if (op == CMD_ENQ)
        begin
            if (model_depth >= QUEUE_SLOTS)
                r.status = ST_FULL;
            else
            begin
                grp_idx = int'(grp) % TEAM_SLOTS;
                // Take a recycled node first, else the next fresh one
                if (recycle_ok)
                begin
                    slot = recycle_head;
                    if (slot >= QUEUE_SLOTS)
                        slot = 0;
                    recycle_head = node_link[slot];
                    recycle_ok   = (pool_used - model_depth) > 1;
                end
                else
                begin
                    slot = pool_used;
                    pool_used++;
                end
                node_value[slot] = value;
                node_group[slot] = grp;
                // Link the node: empty queue, new team at tail, or behind its team
                if (model_depth == 0)
                begin
                    head_idx = slot;
                    tail_idx = slot;
                    node_link[slot] = 0;
                end
                else if (!group_open[grp_idx])
                begin
                    node_link[tail_idx] = slot;
                    node_link[slot] = 0;
                    tail_idx = slot;
                end
                else
                begin
                    last = group_last[grp_idx];
                    node_link[slot] = node_link[last];
                    node_link[last] = slot;
                    if (last == tail_idx)
                        tail_idx = slot;
                end
                group_open[grp_idx] = 1'b1;
                group_last[grp_idx] = slot;
                model_depth++;
            end
        end
        else
        begin
            if (model_depth == 0)
                r.status = ST_EMPTY;
            else
            begin
                slot    = head_idx;
                grp_idx = int'(node_group[slot]) % TEAM_SLOTS;
                r.element = node_value[slot];
                r.team    = node_group[slot];
                if (group_open[grp_idx] && group_last[grp_idx] == slot)
                    group_open[grp_idx] = 1'b0;
                head_idx = node_link[slot];
                model_depth--;
                // Push the freed node onto the free list
                node_link[slot] = recycle_head;
                recycle_head = slot;
                recycle_ok   = 1'b1;
                r.status = ST_DEQ;
            end
        end
        r.occupancy = OCC_W'(model_depth);
        return r;
    endfunction

    // Offer one transaction and record its predicted result on acceptance.
    // Entered and left at a falling edge.
    task automatic send_command(input command_t op, input logic [ELEM_W-1:0] value,
                                input logic [TEAM_W-1:0] grp);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command  = op;
        element  = value;
        team     = grp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(team_queue_step(op, value, grp));
        @(negedge clk);
    endtask

    // Change traffic shaping away from the falling edge where it is read
    task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
        @(posedge clk);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        @(negedge clk);
    endtask

    // Hold the sender until every predicted result has arrived
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Drive the result stall: long hold-off when requested, else random idling
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            out_stall = 1'b1;
            stall_hold--;
        end
        else
            out_stall = ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // Check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: status %0d element %h team %h occupancy %0d",
                             status, out_element, out_team, occupancy);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || out_element !== want.element ||
                    out_team !== want.team || occupancy !== want.occupancy)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                                 want.status, want.element, want.team, want.occupancy,
                                 status, out_element, out_team, occupancy);
                end
            end
        end
    end

    // Empty dequeues, field extremes, insertion behind a team, team leaving and returning
    task automatic test_directed();
        set_idle(0, 0);
        send_command(CMD_DEQ, ELEM_MAX, TEAM_MAX);
        send_command(CMD_ENQ, '0, '0);
        send_command(CMD_ENQ, ELEM_MAX, TEAM_MAX);
        send_command(CMD_ENQ, 20'hAAAAA, 10'h155);
        send_command(CMD_ENQ, 20'h55555, 10'h2AA);
        send_command(CMD_ENQ, 20'h00001, '0);
        send_command(CMD_ENQ, 20'h80000, TEAM_MAX);
        send_command(CMD_ENQ, 20'h12345, 10'h2AA);
        send_command(CMD_ENQ, 20'h00002, '0);
        repeat (8)
            send_command(CMD_DEQ, '0, '0);
        send_command(CMD_DEQ, 20'h5A5A5, 10'h3C3);
        send_command(CMD_ENQ, 20'h00007, '0);
        send_command(CMD_DEQ, '0, '0);
        send_command(CMD_ENQ, 20'h00008, '0);
        send_command(CMD_ENQ, 20'h00009, 10'h001);
        send_command(CMD_ENQ, 20'h0000A, '0);
        repeat (3)
            send_command(CMD_DEQ, '0, '0);
        wait_drained();
    endtask

    // Fill to capacity, enqueue into the full queue, then take a few from the front
    task automatic test_full_queue();
        int unsigned group_pick [16];
        foreach (group_pick[i])
            group_pick[i] = $urandom_range(0, TEAM_SLOTS - 1);
        set_idle(0, 0);
        while (model_depth < QUEUE_SLOTS)
            send_command(CMD_ENQ, ELEM_W'($urandom()),
                         TEAM_W'(group_pick[$urandom_range(0, 15)]));
        send_command(CMD_ENQ, ELEM_MAX, TEAM_MAX);
        send_command(CMD_ENQ, '0, '0);
        repeat (16)
            send_command(CMD_DEQ, ELEM_W'($urandom()), TEAM_W'($urandom()));
        wait_drained();
    endtask

    // Random mix over a small team pool with bursts biased toward filling or draining
    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input int count);
        int unsigned group_pick [8];
        int unsigned enq_bias;
        logic [TEAM_W-1:0] grp;
        foreach (group_pick[i])
            group_pick[i] = $urandom_range(0, TEAM_SLOTS - 1);
        enq_bias = 50;
        set_idle(send_pct, recv_pct);
        for (int n = 0; n < count; n++)
        begin
            if (n % 32 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: enq_bias = 75;
                    1: enq_bias = 30;
                    default: enq_bias = 55;
                endcase
            end
            if ($urandom_range(0, 99) < 80)
                grp = TEAM_W'(group_pick[$urandom_range(0, 7)]);
            else
                grp = TEAM_W'($urandom_range(0, TEAM_SLOTS - 1));
            if ($urandom_range(0, 99) < enq_bias)
                send_command(CMD_ENQ, ELEM_W'($urandom()), grp);
            else
                send_command(CMD_DEQ, ELEM_W'($urandom()), grp);
        end
        wait_drained();
    endtask

    // Hold off the receiver long enough that the block backs up and stalls its input
    task automatic test_backpressure();
        set_idle(0, 0);
        @(posedge clk);
        stall_hold = 300;
        @(negedge clk);
        for (int n = 0; n < 40; n++)
            send_command((n % 3 == 2) ? CMD_DEQ : CMD_ENQ, ELEM_W'($urandom()),
                         TEAM_W'($urandom_range(0, 3)));
        // Pause the sender until every result is back, then resume
        wait_drained();
        for (int n = 0; n < 20; n++)
            send_command((n % 2 == 1) ? CMD_DEQ : CMD_ENQ, ELEM_W'($urandom()),
                         TEAM_W'($urandom_range(0, 3)));
        wait_drained();
    endtask

    // Sequence the tests and report the outcome
    initial
    begin
        clear_model();
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_queue();
        test_random_traffic(13, 74, 40);
        test_backpressure();
        test_random_traffic(74, 13, 40);
        test_random_traffic(0, 0, 40);

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("team_grouped_queue_test passed");
        else
            $display("team_grouped_queue_test failed");
        $finish;
    end

    // End a hung run
    initial
    begin
        #4ms;
        $display("team_grouped_queue_test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tgq_pkg.sv
rtl/tgq_node_mem.sv
rtl/tgq_tail_mem.sv
rtl/tgq_team_index.sv
rtl/team_grouped_queue.sv
tb/sv/team_grouped_queue_test.sv
